[rtl/blim_pkg.sv]
// Package for the bicubic Lagrange inverse map block.
// Holds fixed-point constants, register indexes, the 1-D basis coefficient table
// and saturation helpers. No dependencies.
package blim_pkg;

	// Fixed-point format of the local coordinates.
	localparam int LFRAC = 28;
	localparam int COORD_W = 32;
	localparam int TOL_W = 29;
	localparam int ITER_W = 8;
	localparam int SLOT_W = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	// Multiplier operand and product widths.
	localparam int MUL_W = 48;
	localparam int PROD_W = 2 * MUL_W;
	// Basis values and derivatives.
	localparam int BAS_W = 40;
	// Powers of the local coordinate.
	localparam int POW_W = 34;
	// Node sums and Jacobian accumulators.
	localparam int ACC_W = 48;
	// Cramer numerators and determinant.
	localparam int WIDE_W = 64;

	// Operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MAP = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 1'b1;

	// Register reset values.
	localparam logic [TOL_W-1:0] TOL_RESET = 29'd26844;
	localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd100;

	// 1.1 rounded to nearest, the local coordinate limit and the increment limit.
	localparam logic signed [31:0] ONE_ONE = 32'(((64'd11 << LFRAC) + 64'd5) / 64'd10);
	localparam logic signed [31:0] XI_LIMIT = 32'(64'd2 << LFRAC);
	localparam logic [31:0] INC_MAG = 32'(64'd4 << LFRAC);
	localparam logic signed [31:0] SAT31 = 32'sh7fff_ffff;

	// Coefficients over 16 of one basis polynomial, highest power first.
	typedef struct packed {
		logic signed [7:0] c3;
		logic signed [7:0] c2;
		logic signed [7:0] c1;
		logic signed [7:0] c0;
	} basis_coef_t;

	// Entries 0..3 are the shape values, 4..7 their derivatives.
	function automatic basis_coef_t basis_coef(input logic [2:0] e);
		basis_coef_t c;
		unique case (e)
			3'd0: c = '{c3: -8'sd9, c2: 8'sd9, c1: 8'sd1, c0: -8'sd1};
			3'd1: c = '{c3: 8'sd27, c2: -8'sd9, c1: -8'sd27, c0: 8'sd9};
			3'd2: c = '{c3: -8'sd27, c2: -8'sd9, c1: 8'sd27, c0: 8'sd9};
			3'd3: c = '{c3: 8'sd9, c2: 8'sd9, c1: -8'sd1, c0: -8'sd1};
			3'd4: c = '{c3: 8'sd0, c2: -8'sd27, c1: 8'sd18, c0: 8'sd1};
			3'd5: c = '{c3: 8'sd0, c2: 8'sd81, c1: -8'sd18, c0: -8'sd27};
			3'd6: c = '{c3: 8'sd0, c2: -8'sd81, c1: -8'sd18, c0: 8'sd27};
			default: c = '{c3: 8'sd0, c2: 8'sd27, c1: 8'sd18, c0: -8'sd1};
		endcase
		return c;
	endfunction

	// Saturate a wide signed value to +-(2^31-1).
	function automatic logic signed [31:0] sat31(input logic signed [49:0] v);
		if (v > 50'(SAT31)) begin
			return SAT31;
		end else if (v < -50'(SAT31)) begin
			return -SAT31;
		end
		return v[31:0];
	endfunction

endpackage

[rtl/blim_if.sv]
// Channel interfaces of the bicubic Lagrange inverse map block.
// Point input, result output and configuration write channels; uses blim_pkg.
interface blim_point_if import blim_pkg::*; ();
	logic valid;
	logic ready;
	logic operation;
	logic [SLOT_W-1:0] node_slot;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	modport source (output valid, operation, node_slot, coord_x, coord_y, input ready);
	modport sink (input valid, operation, node_slot, coord_x, coord_y, output ready);
endinterface

interface blim_result_if import blim_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [31:0] local_xi;
	logic signed [31:0] local_eta;
	logic converged;
	logic [ITER_W-1:0] iterations_used;
	modport source (output valid, local_xi, local_eta, converged, iterations_used, input ready);
	modport sink (input valid, local_xi, local_eta, converged, iterations_used, output ready);
endinterface

interface blim_cfg_if import blim_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/blim_mul.sv]
// Shared multi-cycle signed multiplier of the inverse map block.
// Multiplies 48 x 48 bits in three 17 x 48 partial products; uses blim_pkg.
module blim_mul import blim_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [MUL_W-1:0] a,
	input  logic signed [MUL_W-1:0] b,
	output logic done,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [MUL_W-1:0] a_q;
	logic signed [MUL_W-1:0] b_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic signed [16:0] chunk;
	logic signed [MUL_W+16:0] part;
	logic signed [PROD_W-1:0] part_ext;

	// Low chunks are unsigned, the top chunk carries the sign.
	always_comb begin
		unique case (cnt_q)
			2'd0: chunk = $signed({1'b0, a_q[15:0]});
			2'd1: chunk = $signed({1'b0, a_q[31:16]});
			default: chunk = $signed({a_q[47], a_q[47:32]});
		endcase
		part = chunk * b_q;
		part_ext = PROD_W'(part) <<< {cnt_q, 4'b0000};
	end

	// One partial product is added each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q <= a;
				b_q <= b;
				acc_q <= '0;
				cnt_q <= 2'd0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + part_ext;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[rtl/blim_div.sv]
// Iterative restoring divider of the inverse map block.
// Gives num / den in Q4.28, truncated toward zero, magnitude capped at 4.0; uses blim_pkg.
module blim_div import blim_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [WIDE_W-1:0] num,
	input  logic signed [WIDE_W-1:0] den,
	output logic done,
	output logic signed [31:0] quo
);

	localparam int STEPS = LFRAC + 2;

	logic [WIDE_W-1:0] n_q;
	logic [WIDE_W+1:0] dd_q;
	logic [WIDE_W+2:0] rem_q;
	logic [STEPS-1:0] q_q;
	logic [4:0] cnt_q;
	logic neg_q;
	logic busy_q;
	logic chk_q;
	logic done_q;
	logic signed [31:0] quo_q;
	logic [WIDE_W+2:0] rem2;
	logic fit;
	logic [STEPS-1:0] q_next;

	// One quotient bit per cycle against four times the divisor.
	always_comb begin
		rem2 = {rem_q[WIDE_W+1:0], 1'b0};
		fit = rem2 >= {1'b0, dd_q};
		q_next = {q_q[STEPS-2:0], fit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q <= num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
				dd_q <= {(den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den)), 2'b00};
				neg_q <= num[WIDE_W-1] ^ den[WIDE_W-1];
				busy_q <= 1'b1;
				chk_q <= 1'b1;
			end else if (busy_q && chk_q) begin
				// A quotient of four or more saturates.
				chk_q <= 1'b0;
				if ({3'b000, n_q} >= {1'b0, dd_q}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quo_q <= neg_q ? -$signed(INC_MAG) : $signed(INC_MAG);
				end else begin
					rem_q <= {3'b000, n_q};
					q_q <= '0;
					cnt_q <= '0;
				end
			end else if (busy_q) begin
				if (fit) begin
					rem_q <= rem2 - {1'b0, dd_q};
				end else begin
					rem_q <= rem2;
				end
				q_q <= q_next;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quo_q <= neg_q ? -$signed({2'b00, q_next}) : $signed({2'b00, q_next});
				end
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

[rtl/bicubic_lagrange_inverse_map.sv]
// Bicubic Lagrange inverse map: node load and Newton-Raphson local coordinate search.
// Operation: a load writes one node slot as it is accepted; each Newton iteration of a map
// runs 16 nodes x 9 products on the shared multiplier plus two divides, for up to
// max_iterations iterations.
// Throughput: one transaction at a time; the multiplier sets the iteration time.
// Reset: asynchronous, active low; registers return to tolerance 26844 and 100 iterations.
module bicubic_lagrange_inverse_map import blim_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	blim_point_if.sink point_in,
	blim_result_if.source result_out,
	blim_cfg_if.sink cfg
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_BMUL = 4'd1;
	localparam logic [3:0] S_POLY = 4'd2;
	localparam logic [3:0] S_NODE = 4'd3;
	localparam logic [3:0] S_CLAMP = 4'd4;
	localparam logic [3:0] S_SOLVE = 4'd5;
	localparam logic [3:0] S_DIV0 = 4'd6;
	localparam logic [3:0] S_DIV1 = 4'd7;
	localparam logic [3:0] S_UPD = 4'd8;
	localparam logic [3:0] S_FIN = 4'd9;

	logic [3:0] state_q;
	logic pend_q;
	logic axis_q;
	logic [3:0] op_q;
	logic [2:0] ent_q;
	logic [3:0] node_q;
	logic [ITER_W-1:0] iter_q;
	logic conv_q;
	logic [TOL_W-1:0] tol_q;
	logic [ITER_W-1:0] max_iter_q;

	logic signed [31:0] gx_q, gy_q, xi_q, eta_q;
	logic signed [POW_W-1:0] x2_q, x3_q;
	logic signed [BAS_W-1:0] lx_q [4];
	logic signed [BAS_W-1:0] dx_q [4];
	logic signed [BAS_W-1:0] ly_q [4];
	logic signed [BAS_W-1:0] dy_q [4];
	logic signed [ACC_W-1:0] n_q, gxi_q, get_q;
	logic signed [ACC_W-1:0] j00_q, j01_q, j10_q, j11_q, sx_q, sy_q;
	logic signed [31:0] c00_q, c01_q, c10_q, c11_q, r0_q, r1_q;
	logic signed [WIDE_W-1:0] t_q, det_q, n0_q, n1_q;
	logic signed [31:0] d0_q;

	logic signed [COORD_W-1:0] node_x_mem [16];
	logic signed [COORD_W-1:0] node_y_mem [16];
	logic signed [COORD_W-1:0] cx_q, cy_q;

	logic out_valid_q;
	logic signed [31:0] out_xi_q, out_eta_q;
	logic out_conv_q;
	logic [ITER_W-1:0] out_used_q;

	logic mul_start, mul_done;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod, prod_sh;
	logic div_start, div_done;
	logic signed [WIDE_W-1:0] div_num;
	logic signed [31:0] div_quo;

	logic accept;
	logic [1:0] ni, nj;
	logic signed [31:0] x_cur;
	basis_coef_t coef;
	logic signed [43:0] poly_sum;
	logic signed [BAS_W-1:0] poly_val;
	logic signed [32:0] xi_sum, eta_sum;
	logic signed [31:0] xi_new, eta_new;
	logic [31:0] m0, m1, m_max;

	assign point_in.ready = (state_q == S_IDLE);
	assign accept = point_in.valid && point_in.ready;
	assign cfg.ready = 1'b1;
	assign ni = node_q[1:0];
	assign nj = node_q[3:2];
	assign x_cur = axis_q ? eta_q : xi_q;
	assign prod_sh = prod >>> LFRAC;

	// Node coordinate stores with registered read.
	always_ff @(posedge clk) begin
		if (accept && point_in.operation == OP_LOAD) begin
			node_x_mem[point_in.node_slot] <= point_in.coord_x;
			node_y_mem[point_in.node_slot] <= point_in.coord_y;
		end
		cx_q <= node_x_mem[node_q];
		cy_q <= node_y_mem[node_q];
	end

	// One basis polynomial per cycle from the stored powers.
	always_comb begin
		coef = basis_coef(ent_q);
		poly_sum = 44'(coef.c3) * 44'(x3_q) + 44'(coef.c2) * 44'(x2_q)
			+ 44'(coef.c1) * 44'(x_cur) + (44'(coef.c0) <<< LFRAC);
		poly_val = BAS_W'(poly_sum >>> 4);
	end

	// Multiplier operand selection by step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_BMUL: begin
				mul_a = (op_q == 4'd0) ? MUL_W'(x_cur) : MUL_W'(x2_q);
				mul_b = MUL_W'(x_cur);
			end
			S_NODE: begin
				unique case (op_q)
					4'd0: begin mul_a = MUL_W'(lx_q[ni]); mul_b = MUL_W'(ly_q[nj]); end
					4'd1: begin mul_a = MUL_W'(dx_q[ni]); mul_b = MUL_W'(ly_q[nj]); end
					4'd2: begin mul_a = MUL_W'(lx_q[ni]); mul_b = MUL_W'(dy_q[nj]); end
					4'd3: begin mul_a = gxi_q; mul_b = MUL_W'(cx_q); end
					4'd4: begin mul_a = get_q; mul_b = MUL_W'(cx_q); end
					4'd5: begin mul_a = gxi_q; mul_b = MUL_W'(cy_q); end
					4'd6: begin mul_a = get_q; mul_b = MUL_W'(cy_q); end
					4'd7: begin mul_a = n_q; mul_b = MUL_W'(cx_q); end
					default: begin mul_a = n_q; mul_b = MUL_W'(cy_q); end
				endcase
			end
			S_SOLVE: begin
				unique case (op_q)
					4'd0: begin mul_a = MUL_W'(c00_q); mul_b = MUL_W'(c11_q); end
					4'd1: begin mul_a = MUL_W'(c01_q); mul_b = MUL_W'(c10_q); end
					4'd2: begin mul_a = MUL_W'(r0_q); mul_b = MUL_W'(c11_q); end
					4'd3: begin mul_a = MUL_W'(c01_q); mul_b = MUL_W'(r1_q); end
					4'd4: begin mul_a = MUL_W'(c00_q); mul_b = MUL_W'(r1_q); end
					default: begin mul_a = MUL_W'(c10_q); mul_b = MUL_W'(r0_q); end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_start = !pend_q && (state_q == S_BMUL || state_q == S_NODE || state_q == S_SOLVE);
		div_start = !pend_q && (state_q == S_DIV0 || state_q == S_DIV1);
		div_num = (state_q == S_DIV1) ? n1_q : n0_q;
	end

	blim_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	blim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Coordinate update with clamping and the convergence test.
	always_comb begin
		xi_sum = 33'(xi_q) + 33'(d0_q);
		eta_sum = 33'(eta_q) + 33'(div_quo);
		if (xi_sum > 33'(XI_LIMIT)) xi_new = XI_LIMIT;
		else if (xi_sum < -33'(XI_LIMIT)) xi_new = -XI_LIMIT;
		else xi_new = xi_sum[31:0];
		if (eta_sum > 33'(XI_LIMIT)) eta_new = XI_LIMIT;
		else if (eta_sum < -33'(XI_LIMIT)) eta_new = -XI_LIMIT;
		else eta_new = eta_sum[31:0];
		m0 = d0_q[31] ? 32'(-d0_q) : 32'(d0_q);
		m1 = div_quo[31] ? 32'(-div_quo) : 32'(div_quo);
		m_max = (m1 > m0) ? m1 : m0;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q <= 1'b0;
			axis_q <= 1'b0;
			op_q <= '0;
			ent_q <= '0;
			node_q <= '0;
			iter_q <= '0;
			conv_q <= 1'b0;
			tol_q <= TOL_RESET;
			max_iter_q <= MAX_ITER_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// Configuration writes.
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_TOLERANCE) begin
					tol_q <= cfg.data[TOL_W-1:0];
				end else if (cfg.index == REG_MAX_ITER) begin
					max_iter_q <= cfg.data[ITER_W-1:0];
				end
			end
			if (result_out.valid && result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && point_in.operation == OP_MAP) begin
						gx_q <= point_in.coord_x;
						gy_q <= point_in.coord_y;
						xi_q <= '0;
						eta_q <= '0;
						axis_q <= 1'b0;
						op_q <= '0;
						pend_q <= 1'b0;
						conv_q <= 1'b0;
						if (max_iter_q == '0) begin
							iter_q <= '0;
							state_q <= S_FIN;
						end else begin
							iter_q <= 8'd1;
							state_q <= S_BMUL;
						end
					end
				end
				S_BMUL: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (mul_done) begin
						pend_q <= 1'b0;
						if (op_q == 4'd0) begin
							x2_q <= prod_sh[POW_W-1:0];
							op_q <= 4'd1;
						end else begin
							x3_q <= prod_sh[POW_W-1:0];
							op_q <= '0;
							ent_q <= '0;
							state_q <= S_POLY;
						end
					end
				end
				S_POLY: begin
					if (!axis_q) begin
						if (!ent_q[2]) lx_q[ent_q[1:0]] <= poly_val;
						else dx_q[ent_q[1:0]] <= poly_val;
					end else begin
						if (!ent_q[2]) ly_q[ent_q[1:0]] <= poly_val;
						else dy_q[ent_q[1:0]] <= poly_val;
					end
					ent_q <= ent_q + 3'd1;
					if (ent_q == 3'd7) begin
						if (!axis_q) begin
							axis_q <= 1'b1;
							state_q <= S_BMUL;
						end else begin
							node_q <= '0;
							op_q <= '0;
							j00_q <= '0;
							j01_q <= '0;
							j10_q <= '0;
							j11_q <= '0;
							sx_q <= '0;
							sy_q <= '0;
							state_q <= S_NODE;
						end
					end
				end
				S_NODE: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (mul_done) begin
						pend_q <= 1'b0;
						unique case (op_q)
							4'd0: n_q <= prod_sh[ACC_W-1:0];
							4'd1: gxi_q <= prod_sh[ACC_W-1:0];
							4'd2: get_q <= prod_sh[ACC_W-1:0];
							4'd3: j00_q <= j00_q + prod_sh[ACC_W-1:0];
							4'd4: j01_q <= j01_q + prod_sh[ACC_W-1:0];
							4'd5: j10_q <= j10_q + prod_sh[ACC_W-1:0];
							4'd6: j11_q <= j11_q + prod_sh[ACC_W-1:0];
							4'd7: sx_q <= sx_q + prod_sh[ACC_W-1:0];
							default: sy_q <= sy_q + prod_sh[ACC_W-1:0];
						endcase
						if (op_q == 4'd8) begin
							op_q <= '0;
							if (node_q == 4'd15) begin
								state_q <= S_CLAMP;
							end else begin
								node_q <= node_q + 4'd1;
							end
						end else begin
							op_q <= op_q + 4'd1;
						end
					end
				end
				S_CLAMP: begin
					c00_q <= sat31(50'(j00_q));
					c01_q <= sat31(50'(j01_q));
					c10_q <= sat31(50'(j10_q));
					c11_q <= sat31(50'(j11_q));
					r0_q <= sat31(50'(gx_q) - 50'(sx_q));
					r1_q <= sat31(50'(gy_q) - 50'(sy_q));
					op_q <= '0;
					state_q <= S_SOLVE;
				end
				S_SOLVE: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (mul_done) begin
						pend_q <= 1'b0;
						op_q <= op_q + 4'd1;
						unique case (op_q)
							4'd1: det_q <= t_q - prod[WIDE_W-1:0];
							4'd3: n0_q <= t_q - prod[WIDE_W-1:0];
							4'd5: n1_q <= t_q - prod[WIDE_W-1:0];
							default: t_q <= prod[WIDE_W-1:0];
						endcase
						if (op_q == 4'd5) begin
							// A singular Jacobian ends the search unconverged.
							state_q <= (det_q == '0) ? S_FIN : S_DIV0;
						end
					end
				end
				S_DIV0: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (div_done) begin
						pend_q <= 1'b0;
						d0_q <= div_quo;
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (div_done) begin
						pend_q <= 1'b0;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					xi_q <= xi_new;
					eta_q <= eta_new;
					if (m_max < 32'(tol_q)) begin
						conv_q <= 1'b1;
						state_q <= S_FIN;
					end else if (iter_q == max_iter_q) begin
						state_q <= S_FIN;
					end else begin
						iter_q <= iter_q + 8'd1;
						axis_q <= 1'b0;
						op_q <= '0;
						state_q <= S_BMUL;
					end
				end
				S_FIN: begin
					if (!out_valid_q || result_out.ready) begin
						out_valid_q <= 1'b1;
						out_xi_q <= conv_q ? xi_q : ONE_ONE;
						out_eta_q <= eta_q;
						out_conv_q <= conv_q;
						out_used_q <= iter_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The second increment is still on the divider output in the update cycle.
	assign result_out.valid = out_valid_q;
	assign result_out.local_xi = out_xi_q;
	assign result_out.local_eta = out_eta_q;
	assign result_out.converged = out_conv_q;
	assign result_out.iterations_used = out_used_q;

	// A new result only comes out of the finish step.
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result appeared outside the finish step");

	// A converged result has run at least one iteration.
	a_conv_iters: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_conv_q |-> out_used_q != '0)
		else $error("converged result with no iteration");

	// Checks that the iteration count does not pass the limit during a search.
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> iter_q <= max_iter_q)
		else $error("iteration count beyond limit");

	// A converged xi stays within the clamped range.
	a_xi_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_conv_q |-> (out_xi_q <= XI_LIMIT) && (out_xi_q >= -XI_LIMIT))
		else $error("converged xi out of range");

endmodule
